// ===== hdl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray / box slab intersection unit.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic zero_dir;
        logic in_slab;
    } t_lane_flags;

endpackage

// ===== hdl/rbsi_if.sv =====
// ----------------------------------------------------------------------------
// rbsi interfaces
// Ray, result and configuration channels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface rbsi_ray_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rbsi_res_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] entry_distance;
    modport source (output valid, hit, entry_distance, input ready);
    modport sink   (input valid, hit, entry_distance, output ready);
endinterface

interface rbsi_cfg_if #(parameter int W = 32) ();
    logic                           valid;
    logic                           ready;
    logic [rbsi_pkg::CFG_IDX_W-1:0] index;
    logic [W-1:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rbsi_slab_div.sv =====
// ----------------------------------------------------------------------------
// rbsi_slab_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module rbsi_slab_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [W:0]          i_mag,
    input  logic [W-1:0]        i_dmag,
    input  logic                i_neg,
    output logic signed [W-1:0] o_dist
);
    localparam int NS = W + 1;

    logic [W+F:0] num;
    logic [W+F:0] num_hi;
    logic         ovf;

    logic [W-1:0] r_rem  [NS+1];
    logic [W:0]   r_nlo  [NS+1];
    logic [W:0]   r_q    [NS+1];
    logic [W-1:0] r_dmag [NS+1];
    logic         r_ovf  [NS+1];
    logic         r_neg  [NS+1];

    logic [W-1:0] n_rem [NS];
    logic         n_qb  [NS];

    assign num    = {i_mag, {F{1'b0}}};
    assign num_hi = num >> (W + 1);
    assign ovf    = num_hi >= (W+F+1)'(i_dmag);

    always_comb begin
        for (int j = 0; j < NS; j++) begin
            logic [W:0] part;
            logic [W:0] diff;
            part     = {r_rem[j], r_nlo[j][W]};
            diff     = part - {1'b0, r_dmag[j]};
            n_qb[j]  = part >= {1'b0, r_dmag[j]};
            n_rem[j] = n_qb[j] ? diff[W-1:0] : part[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= num_hi[W-1:0];
            r_nlo[0]  <= num[W:0];
            r_q[0]    <= '0;
            r_dmag[0] <= i_dmag;
            r_ovf[0]  <= ovf;
            r_neg[0]  <= i_neg;
            for (int j = 0; j < NS; j++) begin
                r_rem[j+1]  <= n_rem[j];
                r_nlo[j+1]  <= {r_nlo[j][W-1:0], 1'b0};
                r_q[j+1]    <= {r_q[j][W-1:0], n_qb[j]};
                r_dmag[j+1] <= r_dmag[j];
                r_ovf[j+1]  <= r_ovf[j];
                r_neg[j+1]  <= r_neg[j];
            end
        end
    end

    logic [W:0] q;
    logic       pos_sat;
    logic       neg_sat;

    assign q       = r_q[NS];
    assign pos_sat = r_ovf[NS] || (q[W:W-1] != 2'b00);
    assign neg_sat = r_ovf[NS] || q[W] || (q[W-1] && (q[W-2:0] != '0));

    always_comb begin
        if (!r_neg[NS]) begin
            o_dist = pos_sat ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
        end else begin
            o_dist = neg_sat ? {1'b1, {(W-1){1'b0}}} : -q[W-1:0];
        end
    end

endmodule

// ===== hdl/rbsi_lane.sv =====
// ----------------------------------------------------------------------------
// rbsi_lane
// One axis: slab distances for both bounds, ordered into near and far.
// ----------------------------------------------------------------------------
module rbsi_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_org,
    input  logic signed [W-1:0]   i_dir,
    input  logic signed [W-1:0]   i_bmin,
    input  logic signed [W-1:0]   i_bmax,
    output logic signed [W-1:0]   o_near,
    output logic signed [W-1:0]   o_far,
    output rbsi_pkg::t_lane_flags o_flags
);
    localparam int DLY = W + 3;

    logic signed [W:0]   diff_min;
    logic signed [W:0]   diff_max;
    logic [W:0]          mag_min;
    logic [W:0]          mag_max;
    logic                den_neg;
    logic [W-1:0]        dmag;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;
    logic signed [W-1:0] t1;
    logic signed [W-1:0] t2;
    rbsi_pkg::t_lane_flags flags;
    rbsi_pkg::t_lane_flags r_flags [DLY];
    logic signed [W-1:0] r_near;
    logic signed [W-1:0] r_far;

    assign diff_min = (W+1)'(i_bmin) - (W+1)'(i_org);
    assign diff_max = (W+1)'(i_bmax) - (W+1)'(i_org);
    assign mag_min  = diff_min[W] ? -diff_min : diff_min;
    assign mag_max  = diff_max[W] ? -diff_max : diff_max;
    assign den_neg  = i_dir[W-1];
    assign dmag     = den_neg ? -i_dir : i_dir;
    assign lo       = (i_bmin < i_bmax) ? i_bmin : i_bmax;
    assign hi       = (i_bmin < i_bmax) ? i_bmax : i_bmin;

    assign flags.zero_dir = (i_dir == '0);
    assign flags.in_slab  = !((i_org < lo) || (i_org > hi));

    rbsi_slab_div #(.W(W), .F(F)) u_div_min (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_mag  (mag_min),
        .i_dmag (dmag),
        .i_neg  (diff_min[W] != den_neg),
        .o_dist (t1)
    );

    rbsi_slab_div #(.W(W), .F(F)) u_div_max (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_mag  (mag_max),
        .i_dmag (dmag),
        .i_neg  (diff_max[W] != den_neg),
        .o_dist (t2)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags[0] <= flags;
            for (int k = 1; k < DLY; k++) begin
                r_flags[k] <= r_flags[k-1];
            end
            r_near <= (t1 < t2) ? t1 : t2;
            r_far  <= (t1 < t2) ? t2 : t1;
        end
    end

    assign o_near  = r_near;
    assign o_far   = r_far;
    assign o_flags = r_flags[DLY-1];

endmodule

// ===== hdl/rbsi_merge.sv =====
// ----------------------------------------------------------------------------
// rbsi_merge
// Combine lane results into entry / exit, decide hit and entry distance.
// ----------------------------------------------------------------------------
module rbsi_merge #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_near  [rbsi_pkg::NUM_AXES],
    input  logic signed [W-1:0]   i_far   [rbsi_pkg::NUM_AXES],
    input  rbsi_pkg::t_lane_flags i_flags [rbsi_pkg::NUM_AXES],
    output logic                  o_hit,
    output logic signed [W-1:0]   o_dist
);
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] n_entry;
    logic signed [W-1:0] n_exit;
    logic                n_miss;
    logic signed [W-1:0] r_entry;
    logic signed [W-1:0] r_exit;
    logic                r_miss;
    logic                r_hit;
    logic signed [W-1:0] r_dist;
    logic                miss;

    always_comb begin
        n_entry = MINV;
        n_exit  = MAXV;
        n_miss  = 1'b0;
        for (int a = 0; a < rbsi_pkg::NUM_AXES; a++) begin
            if (i_flags[a].zero_dir) begin
                if (!i_flags[a].in_slab) begin
                    n_miss = 1'b1;
                end
            end else begin
                if (i_near[a] > n_entry) begin
                    n_entry = i_near[a];
                end
                if (i_far[a] < n_exit) begin
                    n_exit = i_far[a];
                end
            end
        end
    end

    assign miss = r_miss || r_exit[W-1] || (r_entry > r_exit);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entry <= n_entry;
            r_exit  <= n_exit;
            r_miss  <= n_miss;
            r_hit   <= !miss;
            r_dist  <= miss ? MAXV : r_entry;
        end
    end

    assign o_hit  = r_hit;
    assign o_dist = r_dist;

endmodule

// ===== hdl/ray_box_slab_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Ray versus axis-aligned box, slab method, signed fixed point, pipelined.
//
//   channel  dir  word
//   i_ray    in   origin_x/y/z, dir_x/y/z
//   o_res    out  hit, entry_distance
//   i_cfg    in   index, data (box_min_x..z, box_max_x..z)
//
// One ray per cycle while the output is not stalled. Each axis lane holds two
// bit-per-stage dividers. The pipeline advances as a whole; a stalled
// output word holds every stage and drops i_ray.ready. Reset clears the valid
// pipeline and loads the box with the full coordinate range.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbsi_ray_if.sink   i_ray,
    rbsi_res_if.source o_res,
    rbsi_cfg_if.sink   i_cfg
);
    localparam int W     = COORD_WIDTH;
    localparam int DEPTH = W + 5;
    localparam int NA    = rbsi_pkg::NUM_AXES;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] r_bmin [NA];
    logic signed [W-1:0] r_bmax [NA];
    logic [DEPTH-1:0]    r_vld;
    logic                en;

    logic signed [W-1:0]   org  [NA];
    logic signed [W-1:0]   dir  [NA];
    logic signed [W-1:0]   near [NA];
    logic signed [W-1:0]   far  [NA];
    rbsi_pkg::t_lane_flags flags [NA];

    assign en          = !r_vld[DEPTH-1] || o_res.ready;
    assign i_ray.ready = en;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_vld[DEPTH-1];

    assign org[0] = i_ray.origin_x;
    assign org[1] = i_ray.origin_y;
    assign org[2] = i_ray.origin_z;
    assign dir[0] = i_ray.dir_x;
    assign dir[1] = i_ray.dir_y;
    assign dir[2] = i_ray.dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_ray.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_bmin[a] <= MINV;
                r_bmax[a] <= MAXV;
            end
        end else if (i_cfg.valid) begin
            case (rbsi_pkg::t_cfg_reg'(i_cfg.index))
                rbsi_pkg::REG_MIN_X: r_bmin[0] <= i_cfg.data;
                rbsi_pkg::REG_MIN_Y: r_bmin[1] <= i_cfg.data;
                rbsi_pkg::REG_MIN_Z: r_bmin[2] <= i_cfg.data;
                rbsi_pkg::REG_MAX_X: r_bmax[0] <= i_cfg.data;
                rbsi_pkg::REG_MAX_Y: r_bmax[1] <= i_cfg.data;
                rbsi_pkg::REG_MAX_Z: r_bmax[2] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    for (genvar a = 0; a < NA; a++) begin : g_lane
        rbsi_lane #(.W(W), .F(FRAC_BITS)) u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_org   (org[a]),
            .i_dir   (dir[a]),
            .i_bmin  (r_bmin[a]),
            .i_bmax  (r_bmax[a]),
            .o_near  (near[a]),
            .o_far   (far[a]),
            .o_flags (flags[a])
        );
    end

    rbsi_merge #(.W(W)) u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_near  (near),
        .i_far   (far),
        .i_flags (flags),
        .o_hit   (o_res.hit),
        .o_dist  (o_res.entry_distance)
    );

endmodule

// ===== tb/sv/ray_box_slab_intersect_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit_test
// Drives rays through the slab intersection unit under several box settings
// and checks each result word against a behavioral model of the unit.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit_test;

    localparam int W = 32;
    localparam int F = 16;
    localparam int LAT = W + 5;
    localparam logic signed [W-1:0] SMAX = 32'sh7fffffff;
    localparam logic signed [W-1:0] SMIN = 32'sh80000000;
    localparam int NUM_RAND = 1450;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic signed [W-1:0] ox, oy, oz, dx, dy, dz;
    } t_ray;

    typedef struct packed {
        logic                hit;
        logic signed [W-1:0] entry_dist;
    } t_res;

    typedef struct {
        t_ray ray;
        logic known;
        t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rbsi_ray_if #(W) ray_ch ();
    rbsi_res_if #(W) res_ch ();
    rbsi_cfg_if #(W) cfg_ch ();

    ray_box_slab_intersect_unit #(.COORD_WIDTH(W), .FRAC_BITS(F)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ray  (ray_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    logic signed [W-1:0] box_lo [3];
    logic signed [W-1:0] box_hi [3];
    t_res   hit_queue [$];
    int     errors;
    longint cycles;
    logic   hold_res;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL ray_box_slab_intersect_unit");
            $finish;
        end
    end

    function automatic logic signed [W-1:0] slab_distance(logic signed [W-1:0] bound,
            logic signed [W-1:0] org, logic signed [W-1:0] dir);
        logic signed [95:0] num;
        logic signed [95:0] q;
        num = ((96'(bound) - 96'(org)) <<< F);
        q = num / 96'(dir);
        if (q > 96'(SMAX)) return SMAX;
        if (q < 96'(SMIN)) return SMIN;
        return q[W-1:0];
    endfunction

    function automatic t_res trace_ray(t_ray r);
        logic signed [W-1:0] o [3];
        logic signed [W-1:0] d [3];
        logic signed [W-1:0] entry, leave, t1, t2, lo, hi;
        logic miss;
        t_res res;
        o = '{r.ox, r.oy, r.oz};
        d = '{r.dx, r.dy, r.dz};
        entry = SMIN;
        leave = SMAX;
        miss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) begin
                lo = (box_lo[a] < box_hi[a]) ? box_lo[a] : box_hi[a];
                hi = (box_lo[a] < box_hi[a]) ? box_hi[a] : box_lo[a];
                if (o[a] < lo || o[a] > hi) miss = 1'b1;
            end else begin
                t1 = slab_distance(box_lo[a], o[a], d[a]);
                t2 = slab_distance(box_hi[a], o[a], d[a]);
                if (t1 > t2) begin
                    lo = t2; hi = t1;
                end else begin
                    lo = t1; hi = t2;
                end
                if (lo > entry) entry = lo;
                if (hi < leave) leave = hi;
            end
        end
        if (leave < 0 || entry > leave) miss = 1'b1;
        res.hit = !miss;
        res.entry_dist = miss ? SMAX : entry;
        return res;
    endfunction

    function automatic logic signed [W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return SMAX - $urandom_range(0, 3);
            2: return SMIN + $urandom_range(0, 3);
            3: return 0;
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    function automatic t_ray rand_ray();
        t_ray r;
        r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
        r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
        return r;
    endfunction

    task automatic write_box_reg(rbsi_pkg::t_cfg_reg idx, logic signed [W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx <= rbsi_pkg::REG_MIN_Z) box_lo[idx] = val;
        else box_hi[idx - rbsi_pkg::REG_MAX_X] = val;
    endtask

    task automatic load_box(logic signed [W-1:0] lx, ly, lz, hx, hy, hz);
        write_box_reg(rbsi_pkg::REG_MIN_X, lx);
        write_box_reg(rbsi_pkg::REG_MIN_Y, ly);
        write_box_reg(rbsi_pkg::REG_MIN_Z, lz);
        write_box_reg(rbsi_pkg::REG_MAX_X, hx);
        write_box_reg(rbsi_pkg::REG_MAX_Y, hy);
        write_box_reg(rbsi_pkg::REG_MAX_Z, hz);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_ray(t_ray r, logic known, t_res res);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            ray_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= r.ox; ray_ch.origin_y <= r.oy; ray_ch.origin_z <= r.oz;
        ray_ch.dir_x    <= r.dx; ray_ch.dir_y    <= r.dy; ray_ch.dir_z    <= r.dz;
        @(posedge i_clk);
        while (!ray_ch.ready) @(posedge i_clk);
        hit_queue.push_back(known ? res : trace_ray(r));
        if (known && res != trace_ray(r)) begin
            $display("%0t table row disagrees with model", $time);
            errors++;
        end
    endtask

    task automatic drain();
        ray_ch.valid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (hit_queue.size() == 0) begin
                $display("%0t unexpected word hit=%0b dist=%0d", $time,
                         res_ch.hit, res_ch.entry_distance);
                errors++;
            end else begin
                exp_res = hit_queue.pop_front();
                if (res_ch.hit !== exp_res.hit)
                    $display("%0t hit expected %0b actual %0b", $time,
                             exp_res.hit, res_ch.hit);
                if (res_ch.entry_distance !== exp_res.entry_dist)
                    $display("%0t entry_distance expected %0d actual %0d", $time,
                             exp_res.entry_dist, res_ch.entry_distance);
                if (res_ch.hit !== exp_res.hit ||
                    res_ch.entry_distance !== exp_res.entry_dist)
                    errors++;
            end
        end
    end

    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_res) begin
                res_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
                if (gap != 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_row rows [$];
        t_res none, miss_res;
        none = '0;
        miss_res = '{hit: 1'b0, entry_dist: SMAX};
        errors = 0;
        cycles = 0;
        hold_res = 1'b0;
        i_rst_n <= 1'b0;
        ray_ch.valid <= 1'b0;
        ray_ch.origin_x <= '0; ray_ch.origin_y <= '0; ray_ch.origin_z <= '0;
        ray_ch.dir_x <= '0; ray_ch.dir_y <= '0; ray_ch.dir_z <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= rbsi_pkg::REG_MIN_X;
        cfg_ch.data <= '0;
        box_lo = '{SMIN, SMIN, SMIN};
        box_hi = '{SMAX, SMAX, SMAX};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-range box after reset: all-zero direction is a hit at the minimum
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, SMIN}});
        rows.push_back('{'{SMAX, SMIN, 0, 0, 0, 0}, 1'b1, '{1'b1, SMIN}});
        rows.push_back('{'{0, 0, 0, 32'sh10000, 0, 0}, 1'b0, none});
        rows.push_back('{'{SMIN, SMAX, SMIN, SMAX, SMIN, 1}, 1'b0, none});
        rows.push_back('{'{SMAX, SMAX, SMAX, -1, -1, -1}, 1'b0, none});
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].res);
        drain();

        load_box(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
        rows.delete();
        // zero direction outside the slab is a miss
        rows.push_back('{'{32'sh20000, 0, 0, 0, 32'sh10000, 0}, 1'b1, miss_res});
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, SMIN}});
        // inside: negative entry
        rows.push_back('{'{0, 0, 0, 32'sh10000, 0, 0}, 1'b1, '{1'b1, -32'sh10000}});
        rows.push_back('{'{-32'sh30000, 0, 0, 32'sh10000, 0, 0}, 1'b1, '{1'b1, 32'sh20000}});
        // box behind the ray
        rows.push_back('{'{32'sh30000, 0, 0, 32'sh10000, 0, 0}, 1'b1, miss_res});
        rows.push_back('{'{-32'sh30000, 32'sh30000, 0, 32'sh10000, 0, 0}, 1'b1, miss_res});
        rows.push_back('{'{-32'sh30000, -32'sh30000, -32'sh30000, 32'sh10000, 32'sh10000,
                           32'sh10000}, 1'b0, none});
        rows.push_back('{'{SMIN, 0, 0, 1, 0, 0}, 1'b0, none});
        rows.push_back('{'{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, -1, 1, SMIN}, 1'b0, none});
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].res);
        drain();

        // swapped bounds act as if reordered
        load_box(32'sh50000, 32'sh50000, 32'sh50000, -32'sh50000, -32'sh50000, -32'sh50000);
        send_ray('{-32'sh80000, 0, 0, 32'sh10000, 0, 0}, 1'b1, '{1'b1, 32'sh30000});
        send_ray('{0, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, SMIN});
        send_ray('{SMIN, SMIN, SMIN, SMAX, SMAX, SMAX}, 1'b0, none);
        drain();

        // receiver stalls while the sender keeps going
        fork
            begin
                hold_res = 1'b1;
                repeat (3 * LAT) @(posedge i_clk);
                hold_res = 1'b0;
            end
            for (int i = 0; i < 2 * LAT; i++) send_ray(rand_ray(), 1'b0, none);
        join
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) load_box(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
            else if (phase == 4) load_box(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);
            else load_box(rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord());
            for (int i = 0; i < NUM_RAND / 6; i++) send_ray(rand_ray(), 1'b0, none);
            drain();
        end

        if (errors == 0) begin
            $display("PASS ray_box_slab_intersect_unit");
        end else begin
            $display("FAIL ray_box_slab_intersect_unit");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/rbsi_pkg.sv
hdl/rbsi_if.sv
hdl/rbsi_slab_div.sv
hdl/rbsi_lane.sv
hdl/rbsi_merge.sv
hdl/ray_box_slab_intersect_unit.sv
tb/sv/ray_box_slab_intersect_unit_test.sv
